// ===== src/lrucp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrucp_pkg
// Shared types and constants for the LRU line cache with next-line prefetch.
// ----------------------------------------------------------------------------
package lrucp_pkg;

    // Parameter defaults
    localparam int LINES_DEF      = 16;
    localparam int LINE_BYTES_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;

    // Item field widths
    localparam int ADDR_W   = 32;
    localparam int COST_W   = 32;
    localparam int REQ_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int HIT_COST_W = 16;
    localparam int WIN_W      = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_COST        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_WINDOW = 1'd1;

    localparam logic [HIT_COST_W-1:0] HIT_COST_RESET = 16'd1;
    localparam logic [WIN_W-1:0]      WINDOW_RESET   = 7'd8;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_INSERT,
        ST_FINISH
    } lrucp_state_t;

    // What a shift pass places at the front
    typedef enum logic [1:0] {
        SRC_MOVE,
        SRC_MISS,
        SRC_PF
    } lrucp_src_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       shift_start;
        lrucp_src_t src;
        logic       shift_run;
        logic       finish;
    } lrucp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic pf_want;
        logic shift_done;
        logic out_free;
    } lrucp_status_t;

endpackage

// ===== src/lrucp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrucp_ctrl
// Sequencer: accept, scan the tag store, reorder/insert, then post a result.
// ----------------------------------------------------------------------------
module lrucp_ctrl import lrucp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lrucp_status_t st,
    output lrucp_cmd_t    cmd
);

    lrucp_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_MOVE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (st.scan_done) begin
                    cmd.shift_start = 1'b1;
                    if (st.hit) begin
                        cmd.src    = SRC_MOVE;
                        state_next = ST_MOVE;
                    end else begin
                        cmd.src    = SRC_MISS;
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_MOVE: begin
                cmd.shift_run = 1'b1;
                if (st.shift_done) begin
                    if (st.pf_want) begin
                        cmd.shift_start = 1'b1;
                        cmd.src         = SRC_PF;
                        state_next      = ST_INSERT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_INSERT: begin
                cmd.shift_run = 1'b1;
                if (st.shift_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lrucp_dp.sv =====
// ----------------------------------------------------------------------------
// lrucp_dp
// Tag store memory, scan compare, shift engine, cost total and result register.
// ----------------------------------------------------------------------------
module lrucp_dp import lrucp_pkg::*; #(
    parameter int LINES      = LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [HIT_COST_W-1:0] hit_cost,
    input  logic [WIN_W-1:0]      prefetch_window,
    input  logic                  in_mode,
    input  logic [ADDR_W-1:0]     in_address,
    input  lrucp_cmd_t            cmd,
    output lrucp_status_t         st,
    input  logic                  m_tready,
    output logic                  m_valid,
    output logic                  out_hit,
    output logic [REQ_W-1:0]      out_next_request,
    output logic                  out_prefetch_issued,
    output logic [ADDR_W-1:0]     out_prefetch_address,
    output logic [COST_W-1:0]     out_cost_total
);

    localparam int OFFB = $clog2(LINE_BYTES);
    localparam int IW   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int OCCW = $clog2(LINES + 1);
    localparam int EW   = 2 * ADDR_BITS;
    localparam int SUMW = ((OFFB > WIN_W) ? OFFB : WIN_W) + 1;

    // Entry: line start in the upper half, fill address in the lower half
    logic [EW-1:0] mem [LINES];

    logic                 mode_reg;
    logic [ADDR_BITS-1:0] addr_reg, start_reg, next_reg, fill_reg;
    logic [OCCW-1:0]      occ_reg, occ_next;
    logic [OCCW-1:0]      idx_reg, idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]        cmp_idx_reg;
    logic                 hit_reg, nfound_reg, pf_reg;
    logic [IW-1:0]        pos_reg;
    logic                 wr_pend_reg, wr_pend_next;
    logic [IW-1:0]        wr_addr_reg;
    logic [EW-1:0]        wval_reg, rd_reg;
    logic [COST_W-1:0]    cost_reg, cost_next;
    logic                 m_valid_reg, m_valid_next;

    logic [ADDR_BITS-1:0] addr_in, start_in, next_in;
    logic [ADDR_BITS-1:0] rd_line;
    logic [OFFB-1:0]      offset;
    logic                 win_ok;
    logic [OCCW-1:0]      top_ins, idx_m1;
    logic                 scan_issue, shift_rd, front_wr;
    logic                 rd_en, mem_we;
    logic [IW-1:0]        rd_addr, mem_waddr;
    logic [EW-1:0]        mem_wdata;

    // Line start and next line of the incoming address
    assign addr_in  = (ADDR_BITS)'(in_address);
    assign start_in = {addr_in[ADDR_BITS-1:OFFB], {OFFB{1'b0}}};
    assign next_in  = start_in + (ADDR_BITS)'(LINE_BYTES);

    assign rd_line = rd_reg[EW-1:ADDR_BITS];
    assign offset  = addr_reg[OFFB-1:0];
    assign win_ok  = (SUMW'(offset) + SUMW'(prefetch_window)) > SUMW'(LINE_BYTES);

    // Insert keeps at most LINES-1 older entries
    assign top_ins = (occ_reg == OCCW'(LINES)) ? OCCW'(LINES - 1) : occ_reg;
    assign idx_m1  = idx_reg - 1'b1;

    // Memory port usage
    assign scan_issue = cmd.scan && (idx_reg != occ_reg);
    assign shift_rd   = cmd.shift_run && (idx_reg != '0);
    assign front_wr   = cmd.shift_run && (idx_reg == '0) && !wr_pend_reg;
    assign rd_en      = scan_issue || shift_rd;
    assign rd_addr    = scan_issue ? idx_reg[IW-1:0] : idx_m1[IW-1:0];
    assign mem_we     = wr_pend_reg || front_wr;
    assign mem_waddr  = wr_pend_reg ? wr_addr_reg : '0;
    assign mem_wdata  = wr_pend_reg ? rd_reg : wval_reg;

    // Status to the controller
    assign st.scan_done  = (idx_reg == occ_reg) && !cmp_valid_reg;
    assign st.hit        = hit_reg;
    assign st.pf_want    = hit_reg && (addr_reg > fill_reg) && win_ok && !nfound_reg;
    assign st.shift_done = (idx_reg == '0) && !wr_pend_reg;
    assign st.out_free   = !m_valid_reg || m_tready;

    // Tag store memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Next values of control state
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.shift_start) begin
            idx_next = (cmd.src == SRC_MOVE) ? OCCW'(pos_reg) : top_ins;
        end else if (scan_issue) begin
            idx_next = idx_reg + 1'b1;
        end else if (shift_rd) begin
            idx_next = idx_m1;
        end

        occ_next = occ_reg;
        if (cmd.shift_start && (cmd.src != SRC_MOVE)) begin
            occ_next = top_ins + 1'b1;
        end

        cmp_valid_next = scan_issue;
        wr_pend_next   = shift_rd;

        cost_next = cost_reg;
        if (cmd.finish && hit_reg) begin
            cost_next = cost_reg + COST_W'(hit_cost);
        end

        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            occ_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            cost_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            occ_reg       <= occ_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            cost_reg      <= cost_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Item payload, scan results and shift bookkeeping
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= idx_reg[IW-1:0];
        wr_addr_reg <= idx_reg[IW-1:0];
        if (cmd.load) begin
            mode_reg   <= in_mode;
            addr_reg   <= addr_in;
            start_reg  <= start_in;
            next_reg   <= next_in;
            hit_reg    <= 1'b0;
            nfound_reg <= 1'b0;
            pf_reg     <= 1'b0;
        end else if (cmp_valid_reg) begin
            if (rd_line == start_reg) begin
                hit_reg  <= 1'b1;
                pos_reg  <= cmp_idx_reg;
                fill_reg <= rd_reg[ADDR_BITS-1:0];
            end
            if (rd_line == next_reg) begin
                nfound_reg <= 1'b1;
            end
        end
        if (cmd.shift_start) begin
            case (cmd.src)
                SRC_MOVE: wval_reg <= {start_reg, fill_reg};
                SRC_MISS: wval_reg <= {start_reg, addr_reg};
                SRC_PF: begin
                    wval_reg <= {next_reg, next_reg};
                    pf_reg   <= 1'b1;
                end
                default: wval_reg <= {start_reg, addr_reg};
            endcase
        end
        // Load the result register
        if (cmd.finish) begin
            out_hit              <= hit_reg;
            out_next_request     <= {mode_reg, ~hit_reg};
            out_prefetch_issued  <= pf_reg;
            out_prefetch_address <= pf_reg ? ADDR_W'(next_reg) : '0;
            out_cost_total       <= cost_next;
        end
    end

    assign m_valid = m_valid_reg;

    // Checks
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCCW'(LINES))
        else $error("occupancy above store size");

    a_finish_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("result not posted after finish");

    a_pf_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_prefetch_issued) |-> out_hit)
        else $error("prefetch reported without a hit");

    a_pend_in_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> cmd.shift_run)
        else $error("pending shift write outside a shift pass");

endmodule

// ===== src/lru_line_cache_with_prefetch.sv =====
// ----------------------------------------------------------------------------
// lru_line_cache_with_prefetch
// Fully associative LRU line tag store with next-line prefetch.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one access: s_tuser is the access kind (0 read,
//   1 write), s_tdata the byte address. Each access yields exactly one
//   output beat with hit, next-level request, prefetch flag and address,
//   and the running hit-cost total. Registers hit_cost and prefetch_window
//   are written through cfg_we/cfg_index/cfg_data. They are to be written
//   only while the block is idle; the block itself does not enforce this.
//   Steps per access: accept, scan of the valid entries, reorder (hit) or
//   insert (miss), an optional prefetch insert after a hit, then the result.
//   The tag memory, with one read and one write per cycle, sets the pace:
//   one entry is compared or moved per cycle. One access is in flight at a
//   time; the next beat is taken while a finished result still waits in
//   the output register.
//   Reset empties the store, clears the cost total, and restores
//   hit_cost = 1 and prefetch_window = 8. When m_tready is low the result
//   holds; while an earlier result still waits there, the block stalls in
//   its final step until that beat is taken.
// ----------------------------------------------------------------------------
module lru_line_cache_with_prefetch import lrucp_pkg::*; #(
    parameter int LINES      = LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] address
    input  logic                   s_tuser,   // [0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] hit, [2:1] next_request,
                                              // [3] prefetch_issued,
                                              // [35:4] prefetch_address,
                                              // [67:36] cost_total, [71:68] 0
);

    logic [HIT_COST_W-1:0] hit_cost_reg;
    logic [WIN_W-1:0]      window_reg;
    lrucp_cmd_t            cmd;
    lrucp_status_t         st;
    logic                  o_hit, o_pf;
    logic [REQ_W-1:0]      o_req;
    logic [ADDR_W-1:0]     o_pfa;
    logic [COST_W-1:0]     o_cost;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cost_reg <= HIT_COST_RESET;
            window_reg   <= WINDOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HIT_COST:        hit_cost_reg <= cfg_data;
                REG_PREFETCH_WINDOW: window_reg   <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    lrucp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lrucp_dp #(
        .LINES      (LINES),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .hit_cost             (hit_cost_reg),
        .prefetch_window      (window_reg),
        .in_mode              (s_tuser),
        .in_address           (s_tdata),
        .cmd                  (cmd),
        .st                   (st),
        .m_tready             (m_tready),
        .m_valid              (m_tvalid),
        .out_hit              (o_hit),
        .out_next_request     (o_req),
        .out_prefetch_issued  (o_pf),
        .out_prefetch_address (o_pfa),
        .out_cost_total       (o_cost)
    );

    // Pack the result beat
    assign m_tdata = {4'b0000, o_cost, o_pfa, o_pf, o_req, o_hit};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lru_line_cache_with_prefetch. A shadow copy of the LRU tag
// store predicts every result beat: hit, next-level request, prefetch and
// running cost. Directed accesses cover the reset settings, the prefetch
// window boundary, address-space wrap, an already present next line and the
// fill-address rule. Random traffic then runs over small line pools under
// several register settings. Input pacing, output stalls and one long
// output hold-off are applied, and all results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lrucp_pkg::*;

    localparam int LINES       = LINES_DEF;
    localparam int LINE_BYTES  = LINE_BYTES_DEF;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_LINES  = 24;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } access_mode_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET   = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_PUT   = 2'd2,
        REQ_STORE = 2'd3
    } next_req_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_SPARSE
    } sink_mode_t;

    typedef struct packed {
        logic              hit;
        logic [REQ_W-1:0]  req;
        logic              pf;
        logic [ADDR_W-1:0] pf_addr;
        logic [COST_W-1:0] cost;
    } access_result_t;

    // DUT ports
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [31:0] address
    logic                   s_tuser   = 1'b0; // [0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [0] hit, [2:1] next_request,
                                              // [3] prefetch_issued,
                                              // [35:4] prefetch_address,
                                              // [67:36] cost_total

    // Shadow tag store and registers
    logic [ADDR_W-1:0]     tag_line [LINES];
    logic [ADDR_W-1:0]     tag_fill [LINES];
    int                    tag_count       = 0;
    logic [COST_W-1:0]     cost_sum        = '0;
    logic [HIT_COST_W-1:0] shadow_hit_cost = HIT_COST_RESET;
    logic [WIN_W-1:0]      shadow_window   = WINDOW_RESET;

    access_result_t expected_q [$];
    access_result_t oldest;
    int             error_count = 0;

    // Sender pacing and receiver hold-off control
    bit pace_input  = 1'b1;
    int burst_left  = 0;
    bit hold_req    = 1'b0;

    lru_line_cache_with_prefetch u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow tag store
    // ------------------------------------------------------------------------
    function automatic int find_line(input logic [ADDR_W-1:0] start);
        for (int i = 0; i < tag_count; i++) begin
            if (tag_line[i] == start) return i;
        end
        return -1;
    endfunction

    // Insert at the front, dropping the oldest entry when full
    function automatic void push_line(input logic [ADDR_W-1:0] start,
                                      input logic [ADDR_W-1:0] fill);
        int n;
        n = (tag_count == LINES) ? LINES - 1 : tag_count;
        for (int i = n; i > 0; i--) begin
            tag_line[i] = tag_line[i-1];
            tag_fill[i] = tag_fill[i-1];
        end
        tag_line[0] = start;
        tag_fill[0] = fill;
        tag_count   = n + 1;
    endfunction

    function automatic access_result_t predict_access(input logic mode,
                                                      input logic [ADDR_W-1:0] addr);
        access_result_t    r;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] fill;
        logic [ADDR_W-1:0] nxt;
        int                offset;
        int                pos;
        r      = '0;
        start  = (addr / LINE_BYTES) * LINE_BYTES;
        offset = int'(addr - start);
        pos    = find_line(start);
        r.hit  = (pos >= 0);
        if (r.hit) begin
            fill = tag_fill[pos];
            // Move the hit entry to the front
            for (int i = pos; i > 0; i--) begin
                tag_line[i] = tag_line[i-1];
                tag_fill[i] = tag_fill[i-1];
            end
            tag_line[0] = start;
            tag_fill[0] = fill;
            // Next-line prefetch lands in front of the hit line
            if (addr > fill && offset + int'(shadow_window) > LINE_BYTES) begin
                nxt = start + ADDR_W'(LINE_BYTES);
                if (find_line(nxt) < 0) begin
                    push_line(nxt, nxt);
                    r.pf      = 1'b1;
                    r.pf_addr = nxt;
                end
            end
            cost_sum = cost_sum + COST_W'(shadow_hit_cost);
        end else begin
            push_line(start, addr);
        end
        if (mode == MODE_WRITE) r.req = r.hit ? REQ_PUT : REQ_STORE;
        else                    r.req = r.hit ? REQ_GET : REQ_FETCH;
        r.cost = cost_sum;
        return r;
    endfunction

    // Predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_q.push_back(predict_access(s_tuser, s_tdata));
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no access pending");
                error_count++;
            end else begin
                oldest = expected_q.pop_front();
                check_field("hit", 32'(oldest.hit), 32'(m_tdata[0]));
                check_field("next_request", 32'(oldest.req), 32'(m_tdata[2:1]));
                check_field("prefetch_issued", 32'(oldest.pf), 32'(m_tdata[3]));
                check_field("prefetch_address", oldest.pf_addr, m_tdata[35:4]);
                check_field("cost_total", oldest.cost, m_tdata[67:36]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink
        sink_mode_t sink_mode;
        int         sink_left;
        sink_mode = SINK_OPEN;
        sink_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (sink_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 2));
                sink_left = $urandom_range(5, 200);
            end
            sink_left--;
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
                default:     m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Send one access beat; hold valid across beats inside a burst
    task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        if (pace_input) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid, let the last accepted beat reach the queue, then wait
    // until every pending result has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Write both registers while idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] cost,
                              input logic [CFG_DATA_W-1:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HIT_COST;
        cfg_data  <= cost;
        @(posedge aclk);
        cfg_index <= REG_PREFETCH_WINDOW;
        cfg_data  <= window;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow_hit_cost = cost;
        shadow_window   = window[WIN_W-1:0];
    endtask

    // Mostly a small line pool, half near the line end; some wrap lines and noise
    function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] base);
        int                sel;
        logic [ADDR_W-1:0] line;
        sel = $urandom_range(0, 99);
        if (sel < 5) return $urandom;
        if (sel < 10) begin
            line = 32'hFFFF_FF80 + ADDR_W'($urandom_range(0, 3) * LINE_BYTES);
            return line + ADDR_W'($urandom_range(0, LINE_BYTES - 1));
        end
        line = base + ADDR_W'($urandom_range(0, POOL_LINES - 1) * LINE_BYTES);
        if ($urandom_range(0, 1))
            return line + ADDR_W'($urandom_range(LINE_BYTES - 16, LINE_BYTES - 1));
        return line + ADDR_W'($urandom_range(0, LINE_BYTES - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: cost 1, window 8; window boundary and fill rule
    task automatic test_reset_config();
        send_access(MODE_READ,  32'h0000_1010);   // miss
        send_access(MODE_WRITE, 32'h0000_1010);   // hit at fill, no prefetch
        send_access(MODE_READ,  32'h0000_103F);   // hit past fill, prefetch
        send_access(MODE_READ,  32'h0000_1040);   // prefetched line, at fill
        send_access(MODE_READ,  32'h0000_107F);   // prefetch next line
        send_access(MODE_WRITE, 32'h0000_103F);   // next line present
        send_access(MODE_READ,  32'h8000_0000);   // miss
        send_access(MODE_READ,  32'h8000_0038);   // offset on boundary
        send_access(MODE_WRITE, 32'h8000_0039);   // just inside window
        wait_for_results();
    endtask

    // Last line of the address space wraps to line zero
    task automatic test_address_wrap();
        send_access(MODE_WRITE, 32'hFFFF_FFC0);
        send_access(MODE_READ,  32'hFFFF_FFFF);
        send_access(MODE_READ,  32'h0000_0000);
        wait_for_results();
    endtask

    // Window extremes: wider than a line, zero, exactly a line
    task automatic test_window_extremes();
        set_config(16'hFFFF, 16'hFFFF);             // window masks to 127
        send_access(MODE_READ,  32'h5555_5540);
        send_access(MODE_WRITE, 32'h5555_5541);
        wait_for_results();
        set_config(16'h0000, 16'h0000);
        send_access(MODE_READ,  32'hAAAA_AA80);
        send_access(MODE_READ,  32'hAAAA_AABF);
        wait_for_results();
        set_config(16'h8000, 16'(LINE_BYTES));
        send_access(MODE_WRITE, 32'h1234_5600);
        send_access(MODE_READ,  32'h1234_5601);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] cost,
                                       input logic [CFG_DATA_W-1:0] window,
                                       input int count);
        logic [ADDR_W-1:0] base;
        set_config(cost, window);
        base = $urandom;
        for (int i = 0; i < count; i++) begin
            send_access(1'($urandom_range(0, 1)), pick_address(base));
        end
        wait_for_results();
    endtask

    // Long output hold-off while the sender keeps offering beats
    task automatic test_output_backpressure();
        logic [ADDR_W-1:0] base;
        base       = $urandom;
        pace_input = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_access(1'($urandom_range(0, 1)), pick_address(base));
        end
        pace_input = 1'b1;
        wait_for_results();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_address_wrap();
        test_window_extremes();
        test_random_traffic(16'd1, 16'(WINDOW_RESET), 160);
        test_random_traffic(16'h0000, 16'h0000, 150);
        test_random_traffic(16'hFFFF, 16'h007F, 150);
        test_random_traffic(16'($urandom), 16'(LINE_BYTES), 150);
        test_output_backpressure();
        test_random_traffic(16'($urandom), 16'($urandom), 150);
        test_random_traffic(16'($urandom), 16'($urandom_range(0, 127)), 150);

        repeat (100) @(posedge aclk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
